FILE: rtl/sga_pkg.sv
// shared types and widths for the softened gravity accumulator
// no dependencies
`default_nettype none

package sga_pkg;

    localparam int POS_W      = 32;   // Q8.24 positions
    localparam int MASS_W     = 32;   // Q0.32 mass
    localparam int MAG_W      = 32;   // |dr| always fits in 32 bits
    localparam int SUM_W      = 48;   // Q16.32 accumulators
    localparam int R2_W       = 50;   // r2 stays below 2^50
    localparam int ROOT_W     = 32;   // floor(sqrt(r2 << 14))
    localparam int R2_SHIFT   = 14;
    localparam int SQ_SHIFT   = 16;
    localparam int PHI_W      = 48;   // phi stays below 2^48
    localparam int PHI_SHIFT  = 23;
    localparam int HALF_W     = 24;   // phi split for the 32x24 multiplies
    localparam int ACC_SHIFT  = 8;
    localparam int PROD_W     = 64;
    localparam int DIVN_W     = 88;   // (|dr| * phi) << 8
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic [MAG_W-1:0]  mag_z;
        logic              neg_x;
        logic              neg_y;
        logic              neg_z;
        logic              last;
    } sga_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_PHI_GO,
        ST_PHI_WAIT,
        ST_PM_LO,
        ST_PM_HI,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_FINISH
    } sga_state_t;

endpackage

`default_nettype wire

FILE: rtl/sga_front.sv
// front end: forms the separation vector and splits it into magnitude and sign
// depends on sga_pkg
`default_nettype none

module sga_front
    import sga_pkg::*;
(
    input  wire logic [MASS_W-1:0] src_mass,
    input  wire logic [POS_W-1:0]  src_x,
    input  wire logic [POS_W-1:0]  src_y,
    input  wire logic [POS_W-1:0]  src_z,
    input  wire logic [POS_W-1:0]  target_x,
    input  wire logic [POS_W-1:0]  target_y,
    input  wire logic [POS_W-1:0]  target_z,
    input  wire logic              is_last,
    output sga_entry_t             entry
);

    logic signed [POS_W:0] dx, dy, dz;
    logic        [POS_W:0] nx, ny, nz;

    always_comb
    begin
        dx = $signed({src_x[POS_W-1], src_x}) - $signed({target_x[POS_W-1], target_x});
        dy = $signed({src_y[POS_W-1], src_y}) - $signed({target_y[POS_W-1], target_y});
        dz = $signed({src_z[POS_W-1], src_z}) - $signed({target_z[POS_W-1], target_z});
        nx = -dx;
        ny = -dy;
        nz = -dz;
        entry.mass  = src_mass;
        entry.neg_x = dx[POS_W];
        entry.neg_y = dy[POS_W];
        entry.neg_z = dz[POS_W];
        // difference of two 32-bit values never reaches 2^32 in magnitude
        entry.mag_x = dx[POS_W] ? nx[MAG_W-1:0] : dx[MAG_W-1:0];
        entry.mag_y = dy[POS_W] ? ny[MAG_W-1:0] : dy[MAG_W-1:0];
        entry.mag_z = dz[POS_W] ? nz[MAG_W-1:0] : dz[MAG_W-1:0];
        entry.last  = is_last;
    end

endmodule

`default_nettype wire

FILE: rtl/sga_queue.sv
// small queue between the front end and the force sequencer
// depends on sga_pkg
`default_nettype none

module sga_queue
    import sga_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire sga_entry_t wr_data,
    output logic            full,
    input  wire logic       pop,
    output sga_entry_t      rd_data,
    output logic            empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sga_entry_t       mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sga_divider.sv
// restoring divider, one quotient bit per cycle
// depends on sga_pkg
`default_nettype none

module sga_divider
    import sga_pkg::*;
#(
    parameter int NUM_W = DIVN_W,
    parameter int DEN_W = R2_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial, diff;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
    end

    assign done = done_reg;
    assign quot = num_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= diff[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sga_sqrt.sv
// integer square root, two radicand bits per cycle
// depends on sga_pkg
`default_nettype none

module sga_sqrt
    import sga_pkg::*;
#(
    parameter int RW = ROOT_W
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] x,
    output logic                 done,
    output logic [RW-1:0]        root
);

    localparam int CNT_W = $clog2(RW + 1);

    logic [2*RW-1:0]  x_reg;
    logic [RW-1:0]    root_reg;
    logic [RW+1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [RW+3:0]    trial_rem, trial, diff;

    always_comb
    begin
        trial_rem = {rem_reg, x_reg[2*RW-1:2*RW-2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = trial_rem - trial;
    end

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[2*RW-3:0], 2'b00};
            if (trial_rem >= trial)
            begin
                rem_reg  <= diff[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial_rem[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sga_back.sv
// force sequencer: squares, root, divisions and saturating sums, plus result register
// depends on sga_pkg, sga_divider, sga_sqrt
`default_nettype none

module sga_back
    import sga_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [POS_W-1:0]  softening,
    input  wire sga_entry_t        q_data,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_pop,
    output logic [SUM_W-1:0]       potential,
    output logic [SUM_W-1:0]       accel_x,
    output logic [SUM_W-1:0]       accel_y,
    output logic [SUM_W-1:0]       accel_z
);

    localparam logic [DIVN_W-1:0] TERM_CAP = DIVN_W'(1) << SUM_W;

    sga_state_t        state_reg, state_next;
    sga_entry_t        ent_reg;
    logic [1:0]        sqi_reg, axis_reg;
    logic [PROD_W-1:0] prod_reg, plo_reg;
    logic [R2_W-1:0]   r2_reg, r2_sum;
    logic [PHI_W-1:0]  phi_reg;
    logic signed [SUM_W-1:0] pot_reg, ax_reg, ay_reg, az_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  pot_out_reg, ax_out_reg, ay_out_reg, az_out_reg;

    logic [MAG_W-1:0]  mul_a, mul_b, axis_mag;
    logic              axis_neg, sqrt_start, div_start, emit;
    logic [DIVN_W-1:0] div_num, div_quot;
    logic [R2_W-1:0]   div_den;
    logic              div_done, sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [79:0]       full_prod;
    logic [SUM_W:0]    term_mag;
    logic signed [SUM_W+1:0] term;
    logic signed [SUM_W-1:0] axis_sum, axis_new;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] s,
        input logic signed [SUM_W+1:0] t
    );
        logic signed [SUM_W+2:0] r;
        logic signed [SUM_W+2:0] hi_lim, lo_lim;
        hi_lim = (SUM_W+3)'(signed'({1'b0, {(SUM_W-1){1'b1}}}));
        lo_lim = -hi_lim - 1;
        r = (SUM_W+3)'(s) + (SUM_W+3)'(t);
        if (r > hi_lim)
            return hi_lim[SUM_W-1:0];
        else if (r < lo_lim)
            return lo_lim[SUM_W-1:0];
        else
            return r[SUM_W-1:0];
    endfunction

    sga_divider #(.NUM_W(DIVN_W), .DEN_W(R2_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    sga_sqrt #(.RW(ROOT_W)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     ({r2_reg, R2_SHIFT'(0)}),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // datapath helpers
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin axis_mag = ent_reg.mag_x; axis_neg = ent_reg.neg_x; axis_sum = ax_reg; end
            2'd1:    begin axis_mag = ent_reg.mag_y; axis_neg = ent_reg.neg_y; axis_sum = ay_reg; end
            default: begin axis_mag = ent_reg.mag_z; axis_neg = ent_reg.neg_z; axis_sum = az_reg; end
        endcase
        r2_sum    = r2_reg + R2_W'(prod_reg[PROD_W-1:SQ_SHIFT]);
        full_prod = {prod_reg[55:0], HALF_W'(0)} + 80'(plo_reg[55:0]);
        term_mag  = (div_quot >= TERM_CAP) ? {1'b1, SUM_W'(0)} : div_quot[SUM_W:0];
        term      = axis_neg ? -(SUM_W+2)'(signed'({1'b0, term_mag}))
                             :  (SUM_W+2)'(signed'({1'b0, term_mag}));
        axis_new  = sat_add(axis_sum, term);
        emit      = ent_reg.last && (!out_valid_reg || out_pop);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (!q_empty) state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_SQ_ADD;
            ST_SQ_ADD:
            begin
                if (sqi_reg != 2'd3)
                    state_next = ST_SQ_MUL;
                else if (r2_sum == '0)
                    state_next = ST_FINISH;   // coincident source adds nothing
                else
                    state_next = ST_SQRT_GO;
            end
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (sqrt_done) state_next = ST_PHI_GO;
            ST_PHI_GO:    state_next = ST_PHI_WAIT;
            ST_PHI_WAIT:  if (div_done) state_next = ST_PM_LO;
            ST_PM_LO:     state_next = ST_PM_HI;
            ST_PM_HI:     state_next = ST_ACC_GO;
            ST_ACC_GO:    state_next = ST_ACC_WAIT;
            ST_ACC_WAIT:
            begin
                if (div_done)
                    state_next = (axis_reg == 2'd2) ? ST_FINISH : ST_PM_LO;
            end
            ST_FINISH:    if (!ent_reg.last || emit) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs and operand selection
    always_comb
    begin
        q_pop      = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        mul_a      = axis_mag;
        mul_b      = '0;
        div_num    = {full_prod, ACC_SHIFT'(0)};
        div_den    = r2_reg;
        unique case (state_reg)
            ST_IDLE:    q_pop = !q_empty;
            ST_SQ_MUL:
            begin
                case (sqi_reg)
                    2'd0:    mul_a = ent_reg.mag_x;
                    2'd1:    mul_a = ent_reg.mag_y;
                    2'd2:    mul_a = ent_reg.mag_z;
                    default: mul_a = softening;
                endcase
                mul_b = mul_a;
            end
            ST_SQRT_GO: sqrt_start = 1'b1;
            ST_PHI_GO:
            begin
                div_start = 1'b1;
                div_num   = DIVN_W'({ent_reg.mass, PHI_SHIFT'(0)});
                div_den   = R2_W'(sqrt_root);
            end
            ST_PM_LO:   mul_b = MAG_W'(phi_reg[HALF_W-1:0]);
            ST_PM_HI:   mul_b = MAG_W'(phi_reg[PHI_W-1:HALF_W]);
            ST_ACC_GO:  div_start = 1'b1;
            default:    ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (state_reg == ST_IDLE && !q_empty)
        begin
            ent_reg <= q_data;
        end
        if (state_reg == ST_PM_HI)
        begin
            plo_reg <= prod_reg;
        end
        if (state_reg == ST_PHI_WAIT && div_done)
        begin
            phi_reg <= div_quot[PHI_W-1:0];
        end
        if (state_reg == ST_FINISH && emit)
        begin
            pot_out_reg <= pot_reg;
            ax_out_reg  <= ax_reg;
            ay_out_reg  <= ay_reg;
            az_out_reg  <= az_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sqi_reg       <= '0;
            axis_reg      <= '0;
            r2_reg        <= '0;
            pot_reg       <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // a new result may load in the same cycle the old one is popped
            if (state_reg == ST_FINISH && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    sqi_reg  <= '0;
                    axis_reg <= '0;
                    r2_reg   <= '0;
                end
                ST_SQ_ADD:
                begin
                    r2_reg  <= r2_sum;
                    sqi_reg <= sqi_reg + 1'b1;
                end
                ST_PHI_WAIT:
                begin
                    if (div_done)
                    begin
                        pot_reg <= sat_add(pot_reg,
                            -(SUM_W+2)'(signed'({2'b00, div_quot[PHI_W-1:0]})));
                    end
                end
                ST_ACC_WAIT:
                begin
                    if (div_done)
                    begin
                        case (axis_reg)
                            2'd0:    ax_reg <= axis_new;
                            2'd1:    ay_reg <= axis_new;
                            default: az_reg <= axis_new;
                        endcase
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (emit)
                    begin
                        pot_reg <= '0;
                        ax_reg  <= '0;
                        ay_reg  <= '0;
                        az_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign potential = pot_out_reg;
    assign accel_x   = ax_out_reg;
    assign accel_y   = ay_out_reg;
    assign accel_z   = az_out_reg;

endmodule

`default_nettype wire

FILE: rtl/softened_gravity_accumulator_core.sv
// top level of the softened gravity accumulator
// depends on sga_pkg, sga_front, sga_queue, sga_back
`default_nettype none

// Sums Plummer-softened gravity from a stream of sources onto one target body:
// each beat on the input carries one source and the target position, and the beat
// marked is_last closes the sum and leaves one result beat with potential and
// acceleration in saturated Q16.32. A source whose separation and softening are
// both zero adds nothing. In the sequencer each source is squared, then goes
// through a 32-step square root and the one-bit-per-cycle divider, which runs
// four times per source (phi and the three acceleration terms); when r2 is zero
// the root and the divisions are skipped. A last source waits in the sequencer
// while an earlier result is still unpopped. A short queue holds sources waiting
// for the sequencer, and a result register lets the next source start while a
// result waits to be popped. Softening is written through cfg_we / cfg_wdata,
// only while idle; the user must keep to this, as the block does not enforce it.
module softened_gravity_accumulator_core
    import sga_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [POS_W-1:0]  cfg_wdata,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [MASS_W-1:0] src_mass,
    input  wire logic [POS_W-1:0]  src_x,
    input  wire logic [POS_W-1:0]  src_y,
    input  wire logic [POS_W-1:0]  src_z,
    input  wire logic [POS_W-1:0]  target_x,
    input  wire logic [POS_W-1:0]  target_y,
    input  wire logic [POS_W-1:0]  target_z,
    input  wire logic              is_last,
    output logic                   empty,
    input  wire logic              pop,
    output logic [SUM_W-1:0]       potential,
    output logic [SUM_W-1:0]       accel_x,
    output logic [SUM_W-1:0]       accel_y,
    output logic [SUM_W-1:0]       accel_z
);

    logic [POS_W-1:0] softening_reg;
    sga_entry_t       front_entry, q_data;
    logic             q_empty, q_pop, out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            softening_reg <= '0;
        end
        else if (cfg_we)
        begin
            softening_reg <= cfg_wdata;
        end
    end

    sga_front u_front (
        .src_mass (src_mass),
        .src_x    (src_x),
        .src_y    (src_y),
        .src_z    (src_z),
        .target_x (target_x),
        .target_y (target_y),
        .target_z (target_z),
        .is_last  (is_last),
        .entry    (front_entry)
    );

    sga_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_entry),
        .full    (full),
        .pop     (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    sga_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .softening (softening_reg),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_pop   (pop),
        .potential (potential),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: rtl/sga_checker.sv
// port-level checks for the softened gravity accumulator, bound to the top level
// depends on sga_pkg
`default_nettype none

module sga_checker
    import sga_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             push,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [SUM_W-1:0] potential,
    input wire logic [SUM_W-1:0] accel_x
);

    // nothing waits on the result side while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result present during reset");

    // a waiting beat holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(potential) && $stable(accel_x)))
        else $error("waiting result changed");

    // the input side only fills up on an offered beat
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an input beat");

    // potential only ever gains non-positive terms
    a_pot_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (potential[SUM_W-1] || potential == '0))
        else $error("positive potential");

endmodule

bind softened_gravity_accumulator_core sga_checker u_sga_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .potential (potential),
    .accel_x   (accel_x)
);

`default_nettype wire
